[src/spdpc_pkg.sv]
package spdpc_pkg;

    localparam int BODY_LENGTH = 35;
    localparam int POS_W = 6;
    localparam int PH_W = 4;
    localparam int CNT_W = 3;
    localparam int ITEMS_W = 3;
    localparam int VAL_W = 16;
    localparam int NUM_FIELDS = 6;
    localparam int NUM_DEC_FIELDS = 5;
    localparam int FIDX_W = 3;
    localparam int TDATA_W = 104;
    localparam logic [ITEMS_W-1:0] ITEMS_MAX = 3'd7;

    localparam logic [PH_W-1:0] PH_IDENT = 4'd0;
    localparam logic [PH_W-1:0] PH_LAST_DEC = 4'd9;
    localparam logic [PH_W-1:0] PH_HEX = 4'd11;
    localparam logic [PH_W-1:0] PH_DONE = 4'd12;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic             frame_ok;
        logic [2:0]       items_read;
        logic [VAL_W-1:0] temperature_raw;
        logic [VAL_W-1:0] pressure_raw;
        logic [VAL_W-1:0] wind_direction;
        logic [VAL_W-1:0] wind_speed;
        logic [VAL_W-1:0] aux_voltage;
        logic [VAL_W-1:0] received_sum;
        logic             sum_matches;
        logic             packet_valid;
    } result_t;

    function automatic logic [CNT_W-1:0] phase_width(input logic [PH_W-1:0] ph);
        logic [CNT_W-1:0] w;
        begin
            case (ph)
                4'd0:    w = 3'd4;
                4'd1:    w = 3'd5;
                4'd3:    w = 3'd5;
                4'd5:    w = 3'd4;
                4'd7:    w = 3'd5;
                4'd9:    w = 3'd3;
                4'd11:   w = 3'd4;
                default: w = 3'd0;
            endcase
            return w;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Digit value of a decimal digit or a hex letter of either case.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] d;
        begin
            if (is_dec_digit(c))
                d = c[3:0];
            else
                d = 4'(c[2:0] + 3'd1) + 4'd8;
            return d;
        end
    endfunction

endpackage

[src/spdpc_parser.sv]
module spdpc_parser
    import spdpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_fire,
    input  logic [7:0]    rx_byte,
    output logic          frame_end,
    output result_t       result
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PH_W-1:0]    phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic [ITEMS_W-1:0] items_reg, items_next;
    logic               stop_reg, stop_next;
    logic [VAL_W-1:0]   sum_reg, sum_next;
    logic [VAL_W-1:0]   field_reg [NUM_FIELDS];
    logic [VAL_W-1:0]   field_next [NUM_FIELDS];

    logic               complete;
    logic               sep_ok;
    logic [VAL_W-1:0]   comp_val;
    logic               is_digit;
    logic [3:0]         dval;
    logic [VAL_W-1:0]   acc_digit;
    logic [CNT_W-1:0]   cnt_inc;
    logic [PH_W-1:0]    phase_dec;
    logic [FIDX_W-1:0]  fidx;
    logic               in_field;
    logic               eot_complete;
    logic [VAL_W-1:0]   fin_field [NUM_FIELDS];
    logic [VAL_W-1:0]   fin_sum;

    assign frame_end = (pos_reg == POS_W'(BODY_LENGTH));

    assign phase_dec = phase_reg - 4'd1;
    assign fidx = phase_dec[FIDX_W:1];
    assign cnt_inc = cnt_reg + 3'd1;
    assign in_field = (phase_reg == PH_IDENT) || phase_reg[0];
    assign is_digit = is_dec_digit(rx_byte) ||
                      ((phase_reg == PH_HEX) && is_hex_letter(rx_byte));
    assign dval = digit_value(rx_byte);
    assign acc_digit = (phase_reg == PH_HEX) ? {acc_reg[VAL_W-5:0], dval}
                     : (acc_reg << 3) + (acc_reg << 1) + VAL_W'(dval);

    // A frame end completes a field that is still in progress.
    assign eot_complete = !stop_reg && (phase_reg < PH_DONE) && in_field &&
                          (cnt_reg != '0);

    always_comb
    begin
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            fin_field[i] = field_reg[i];
            if (eot_complete && (phase_reg != PH_IDENT) && (fidx == FIDX_W'(i)))
                fin_field[i] = acc_reg;
        end
        fin_sum = sum_reg;
        if (eot_complete && (phase_reg != PH_IDENT) && (phase_reg <= PH_LAST_DEC))
            fin_sum = sum_reg + acc_reg;
    end

    always_comb
    begin
        result.frame_ok = (rx_byte == CH_STAR);
        result.items_read = (eot_complete && (items_reg != ITEMS_MAX)) ?
                            items_reg + 3'd1 : items_reg;
        result.temperature_raw = fin_field[0];
        result.pressure_raw = fin_field[1];
        result.wind_direction = fin_field[2];
        result.wind_speed = fin_field[3];
        result.aux_voltage = fin_field[4];
        result.received_sum = fin_field[5];
        result.sum_matches = !fin_field[5][VAL_W-1] && (fin_sum == fin_field[5]);
        result.packet_valid = result.frame_ok && result.sum_matches &&
                              (result.items_read == ITEMS_MAX);
    end

    always_comb
    begin
        complete = 1'b0;
        sep_ok = 1'b0;
        comp_val = acc_reg;
        pos_next = pos_reg;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        items_next = items_reg;
        stop_next = stop_reg;
        sum_next = sum_reg;
        for (int i = 0; i < NUM_FIELDS; i++)
            field_next[i] = field_reg[i];

        if (byte_fire && frame_end)
        begin
            pos_next = '0;
            phase_next = PH_IDENT;
            cnt_next = '0;
            acc_next = '0;
            items_next = '0;
            stop_next = 1'b0;
            sum_next = '0;
            for (int i = 0; i < NUM_FIELDS; i++)
                field_next[i] = '0;
        end
        else if (byte_fire)
        begin
            pos_next = pos_reg + 6'd1;
            if (rx_byte == CH_NUL)
            begin
                complete = eot_complete;
                stop_next = 1'b1;
            end
            else if (!stop_reg && (phase_reg < PH_DONE))
            begin
                if (phase_reg == PH_IDENT)
                begin
                    if (is_space(rx_byte))
                        complete = (cnt_reg != '0);
                    else if (cnt_inc >= phase_width(phase_reg))
                        complete = 1'b1;
                    else
                        cnt_next = cnt_inc;
                end
                else if (!phase_reg[0])
                begin
                    if (rx_byte == CH_DOT)
                        phase_next = phase_reg + 4'd1;
                    else
                        stop_next = 1'b1;
                end
                else if (is_digit)
                begin
                    if (cnt_inc >= phase_width(phase_reg))
                    begin
                        complete = 1'b1;
                        comp_val = acc_digit;
                    end
                    else
                    begin
                        acc_next = acc_digit;
                        cnt_next = cnt_inc;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    if (!is_space(rx_byte))
                        stop_next = 1'b1;
                end
                else
                begin
                    // Outside the hex field, the byte that ended the field is examined again as a separator.
                    complete = 1'b1;
                    if (phase_reg != PH_HEX)
                    begin
                        if (rx_byte == CH_DOT)
                            sep_ok = 1'b1;
                        else
                            stop_next = 1'b1;
                    end
                end
            end

            if (complete)
            begin
                if (phase_reg != PH_IDENT)
                begin
                    for (int i = 0; i < NUM_FIELDS; i++)
                        if (fidx == FIDX_W'(i))
                            field_next[i] = comp_val;
                    if (phase_reg <= PH_LAST_DEC)
                        sum_next = sum_reg + comp_val;
                end
                if (items_reg != ITEMS_MAX)
                    items_next = items_reg + 3'd1;
                phase_next = phase_reg + 4'd1 + PH_W'(sep_ok);
                cnt_next = '0;
                acc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            phase_reg <= PH_IDENT;
            cnt_reg <= '0;
            acc_reg <= '0;
            items_reg <= '0;
            stop_reg <= 1'b0;
            sum_reg <= '0;
            for (int i = 0; i < NUM_FIELDS; i++)
                field_reg[i] <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
            items_reg <= items_next;
            stop_reg <= stop_next;
            sum_reg <= sum_next;
            for (int i = 0; i < NUM_FIELDS; i++)
                field_reg[i] <= field_next[i];
        end
    end

    // Every phase past the identifier is reached through one completed field
    // per pair of phases.
    a_items_track: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDENT) |-> (items_reg == 3'(phase_reg[3:1] + 3'd1)))
        else $error("item count out of step with parse phase");

    a_items_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDENT) |-> (items_reg == '0))
        else $error("items counted before the identifier ended");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && frame_end) |=> ((pos_reg == '0) && !stop_reg && (sum_reg == '0)))
        else $error("frame state not cleared after frame end");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_DONE)
        else $error("parse phase beyond done");

endmodule

[src/sensor_packet_deframe_parse_check.sv]
// Sensor packet deframer, parser and checksum checker.
// Bytes enter on s_axis one item per cycle while tready is high. A frame is
// BODY_LENGTH body bytes and one terminator byte; the body is parsed as it
// arrives into an identifier, five decimal fields and a hex checksum.
// The terminator byte produces one result item on the m_axis channel; body
// bytes produce none. m_axis_tuser carries frame_ok, set when the
// terminator was '*'. m_axis_tdata carries the parsed fields and checks.
// Each accepted byte is held in an input register and handled from there;
// a terminator's result goes into the output register that drives m_axis.
// The block sustains one byte per cycle while no terminator waits on a
// stalled receiver, as set by the single parse-state register stage.
// Reset clears the frame position and all parse state; the first byte after
// reset starts a new frame. When the receiver stalls, the output register
// holds its result and body bytes keep flowing; only a second terminator
// waits in the input register, which then deasserts s_axis_tready until the
// output register frees up.
module sensor_packet_deframe_parse_check
    import spdpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // items_read, temperature_raw, pressure_raw, wind_direction, wind_speed,
    // aux_voltage, received_sum, sum_matches, packet_valid, zero fill
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser    // frame_ok
);

    logic               in_valid_reg;
    logic [7:0]         in_data_reg;
    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic               out_user_reg;
    logic               out_free;
    logic               proc_fire;
    logic               frame_end;
    result_t            result;

    spdpc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (proc_fire),
        .rx_byte   (in_data_reg),
        .frame_end (frame_end),
        .result    (result)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign proc_fire = in_valid_reg && (!frame_end || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (proc_fire && frame_end)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_data_reg <= s_axis_tdata;
        if (proc_fire && frame_end)
        begin
            out_user_reg <= result.frame_ok;
            out_data_reg <= {3'b000, result.packet_valid, result.sum_matches,
                             result.received_sum, result.aux_voltage,
                             result.wind_speed, result.wind_direction,
                             result.pressure_raw, result.temperature_raw,
                             result.items_read};
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");

    a_term_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && frame_end && !out_free) |-> !s_axis_tready)
        else $error("input taken while terminator blocked");

    a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && frame_end))
        else $error("result without a terminator byte");

endmodule

[tb/tb_sensor_packet_deframe_parse_check.sv]
module tb_sensor_packet_deframe_parse_check;
    import spdpc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    // Maximum field width by parse phase; index 0 is the identifier.
    localparam logic [11:0][2:0] FIELD_WIDTH = {3'd4, 3'd0, 3'd3, 3'd0, 3'd5, 3'd0,
                                                3'd4, 3'd0, 3'd5, 3'd0, 3'd5, 3'd4};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tuser;

    bit                  idling = 1'b1;
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    result_t             results_due[$];

    logic [5:0]          frame_pos;
    logic [3:0]          phase;
    logic [2:0]          nchars;
    logic [15:0]         acc;
    logic [2:0]          nitems;
    logic                halted;
    logic [15:0]         field_val [0:5];

    sensor_packet_deframe_parse_check u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    function automatic void clear_frame();
        frame_pos = '0;
        phase = PH_IDENT;
        nchars = '0;
        acc = '0;
        nitems = '0;
        halted = 1'b0;
        for (int k = 0; k < NUM_FIELDS; k++)
            field_val[k] = '0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int char_digit(input logic [7:0] c, input bit hex);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (hex && c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (hex && c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void store_field();
        if (phase != PH_IDENT && phase < PH_DONE)
            field_val[(int'(phase) - 1) / 2] = acc;
        if (nitems < ITEMS_MAX)
            nitems++;
        phase++;
        nchars = '0;
        acc = '0;
    endfunction

    function automatic void text_end();
        if (!halted && phase < PH_DONE && (phase == PH_IDENT || phase[0]) && nchars > 0)
            store_field();
        halted = 1'b1;
    endfunction

    // A field that ends on a non-digit hands that character to the next part of the format.
    function automatic void parse_char(input logic [7:0] c);
        int d;
        if (c == CH_NUL)
        begin
            text_end();
            return;
        end
        for (int pass = 0; pass < 2; pass++)
        begin
            if (halted || phase >= PH_DONE)
                return;
            if (phase == PH_IDENT)
            begin
                if (is_blank(c))
                begin
                    if (nchars > 0)
                        store_field();
                end
                else
                begin
                    nchars++;
                    if (nchars >= FIELD_WIDTH[phase])
                        store_field();
                end
                return;
            end
            if (!phase[0])
            begin
                if (c == CH_DOT)
                    phase++;
                else
                    halted = 1'b1;
                return;
            end
            d = char_digit(c, phase == PH_HEX);
            if (d >= 0)
            begin
                if (phase == PH_HEX)
                    acc = {acc[11:0], 4'(d)};
                else
                    acc = 16'(acc * 10 + d);
                nchars++;
                if (nchars >= FIELD_WIDTH[phase])
                    store_field();
                return;
            end
            if (nchars == 0)
            begin
                if (!is_blank(c))
                    halted = 1'b1;
                return;
            end
            store_field();
        end
    endfunction

    function automatic void consume_byte(input logic [7:0] c);
        result_t     r;
        logic [15:0] total;
        if (frame_pos < BODY_LENGTH)
        begin
            parse_char(c);
            frame_pos++;
            return;
        end
        text_end();
        total = '0;
        for (int k = 0; k < NUM_DEC_FIELDS; k++)
            total += field_val[k];
        r.frame_ok = (c == CH_STAR);
        r.items_read = nitems;
        r.temperature_raw = field_val[0];
        r.pressure_raw = field_val[1];
        r.wind_direction = field_val[2];
        r.wind_speed = field_val[3];
        r.aux_voltage = field_val[4];
        r.received_sum = field_val[5];
        r.sum_matches = field_val[5] < 16'h8000 && total == field_val[5];
        r.packet_valid = r.frame_ok && r.sum_matches && nitems == ITEMS_MAX;
        results_due.push_back(r);
        clear_frame();
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            clear_frame();
        else if (s_axis_tvalid && s_axis_tready)
            consume_byte(s_axis_tdata);
    end

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.frame_ok = m_axis_tuser;
            seen.items_read = m_axis_tdata[2:0];
            seen.temperature_raw = m_axis_tdata[18:3];
            seen.pressure_raw = m_axis_tdata[34:19];
            seen.wind_direction = m_axis_tdata[50:35];
            seen.wind_speed = m_axis_tdata[66:51];
            seen.aux_voltage = m_axis_tdata[82:67];
            seen.received_sum = m_axis_tdata[98:83];
            seen.sum_matches = m_axis_tdata[99];
            seen.packet_valid = m_axis_tdata[100];
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result item: %p", seen);
            end
            else
            begin
                want = results_due.pop_front();
                report_field("frame_ok", 16'(want.frame_ok), 16'(seen.frame_ok));
                report_field("items_read", 16'(want.items_read), 16'(seen.items_read));
                report_field("temperature_raw", want.temperature_raw, seen.temperature_raw);
                report_field("pressure_raw", want.pressure_raw, seen.pressure_raw);
                report_field("wind_direction", want.wind_direction, seen.wind_direction);
                report_field("wind_speed", want.wind_speed, seen.wind_speed);
                report_field("aux_voltage", want.aux_voltage, seen.aux_voltage);
                report_field("received_sum", want.received_sum, seen.received_sum);
                report_field("sum_matches", 16'(want.sum_matches), 16'(seen.sum_matches));
                report_field("packet_valid", 16'(want.packet_valid),
                             16'(seen.packet_valid));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
        m_axis_tready <= !idling || $urandom_range(0, 99) >= 8;

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (idling && $urandom_range(0, 99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_frame(input string body, input logic [7:0] pad,
                              input logic [7:0] term);
        for (int k = 0; k < BODY_LENGTH; k++)
            send_byte(k < body.len() ? 8'(body[k]) : pad);
        send_byte(term);
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'd32 : 8'(9 + k);
    endfunction

    task automatic send_random_frame();
        logic [7:0]  body[$];
        logic [15:0] total;
        logic [15:0] v;
        logic [7:0]  pad;
        logic [7:0]  term;
        logic [3:0]  d;
        logic [3:0]  nib;
        int          mode;
        int          ndig;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            repeat (BODY_LENGTH)
                body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 1))
                body.push_back(pick_blank());
            ndig = $urandom_range(1, 4);
            repeat (ndig)
                body.push_back(8'($urandom_range(33, 126)));
            if (ndig < 4)
                body.push_back(pick_blank());
            total = '0;
            for (int k = 0; k < NUM_DEC_FIELDS; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    body.push_back(pick_blank());
                ndig = $urandom_range(1, FIELD_WIDTH[2 * k + 1]);
                v = '0;
                repeat (ndig)
                begin
                    d = 4'($urandom_range(0, 9));
                    v = 16'(v * 10 + d);
                    body.push_back(8'h30 + d);
                end
                total += v;
                body.push_back(CH_DOT);
            end
            if ($urandom_range(0, 4) == 0)
                total = 16'($urandom_range(0, 65535));
            for (int k = 3; k >= 0; k--)
            begin
                nib = total[4 * k +: 4];
                if (nib < 10)
                    body.push_back(8'h30 + nib);
                else
                    body.push_back(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
            end
            if (mode == 1)
                body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 4))
            0:       pad = CH_NUL;
            1:       pad = 8'($urandom_range(0, 255));
            default: pad = 8'd32;
        endcase
        while (body.size() < BODY_LENGTH)
            body.push_back(pad);
        term = CH_STAR;
        if ($urandom_range(0, 9) == 0)
        begin
            term = 8'($urandom_range(0, 255));
            if (term == CH_STAR)
                term = term + 8'd1;
        end
        for (int k = 0; k < BODY_LENGTH; k++)
            send_byte(body[k]);
        send_byte(term);
    endtask

    task automatic test_well_formed_frames();
        send_frame("WXYZ00100.01013.1800.00015.230.0C56", " ", CH_STAR);
        send_frame("wxyz00100.01013.1800.00015.230.0c56", " ", CH_STAR);
        send_frame("ZZZZ99999.99999.9999.99999.999.FFFF", " ", CH_STAR);
        send_frame("A1b20.3.4.5.6.12", " ", CH_STAR);
        send_frame("ABCD12345.23456.3600.00042.123.9A8E", " ", CH_STAR);
    endtask

    task automatic test_whitespace();
        send_frame("ID 1.\t2.\n3.\v4.\f5.\015f", " ", CH_STAR);
        send_frame("  AB 7.8.9.10.11.2D", "\t", CH_STAR);
        send_frame("ABCD1. 2. 3. 4. 5. f", " ", CH_STAR);
    endtask

    task automatic test_parse_mismatch();
        send_frame("ABCD-5.1.1.1.1.5", " ", CH_STAR);
        send_frame("ABCD+5.1.1.1.1.5", " ", CH_STAR);
        send_frame("ABCD123456.1.1.1.1.0", " ", CH_STAR);
        send_frame("ABCD1,2.3.4.5.f", " ", CH_STAR);
        send_frame("ABCD.1.2.3.4.a", " ", CH_STAR);
        send_frame("ABCD1 .2.3.4.5.f", " ", CH_STAR);
        send_frame("ABCD1.2.3.4.5.0x5", " ", CH_STAR);
    endtask

    task automatic test_text_end();
        send_frame("ABCD12", CH_NUL, CH_STAR);
        send_frame("AB", CH_NUL, CH_STAR);
        send_frame("", CH_NUL, CH_STAR);
        send_frame("", " ", CH_STAR);
        send_frame("  ABCD99999.99999.9999.99999.999.FF", " ", CH_STAR);
        send_frame("AB*D1.2.3.4.5.f", "*", CH_STAR);
    endtask

    task automatic test_corrupt_terminator();
        send_frame("WXYZ00100.01013.1800.00015.230.0C56", " ", 8'h23);
        send_frame("WXYZ00100.01013.1800.00015.230.0C56", " ", CH_NUL);
        send_frame("WXYZ00100.01013.1800.00015.230.0C56", " ", 8'hAA);
        send_frame("WXYZ00100.01013.1800.00015.230.0C56", " ", CH_STAR);
    endtask

    task automatic test_random_traffic(input int frames, input bit with_idling);
        idling = with_idling;
        repeat (frames)
            send_random_frame();
        idling = 1'b1;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_well_formed_frames();
        test_whitespace();
        test_parse_mismatch();
        test_text_end();
        test_corrupt_terminator();
        test_random_traffic(1, 1'b1);
        test_random_traffic(2, 1'b0);
        test_random_traffic(1, 1'b1);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/spdpc_pkg.sv
src/spdpc_parser.sv
src/sensor_packet_deframe_parse_check.sv
tb/tb_sensor_packet_deframe_parse_check.sv
